FILE: rtl/tmux_pkg.sv
// Package: types, constants and commands for the timer multiplexer.
package tmux_pkg;

    localparam int TIMERS = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W = 5;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_SETPER = 3'd3,
        CMD_EXPIRE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FIRE,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic exec;
        logic walk_first;
        logic walk_step;
        logic fire_mark;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic is_expire;
        logic walk_fire;
        logic walk_done;
    } stat_t;

endpackage

FILE: rtl/tmux_ctrl.sv
// Controller state machine for the timer multiplexer.
module tmux_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_last,
    output tmux_pkg::ctrl_t ctrl,
    input  tmux_pkg::stat_t stat
);

    tmux_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tmux_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_last = 1'b0;
        ctrl = '0;
        unique case (state_reg)
            tmux_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = tmux_pkg::ST_EXEC;
            end
            tmux_pkg::ST_EXEC:
            begin
                if (stat.is_expire)
                begin
                    ctrl.walk_first = 1'b1;
                    state_next = tmux_pkg::ST_WALK;
                end
                else
                begin
                    ctrl.exec = 1'b1;
                    state_next = tmux_pkg::ST_OUT;
                end
            end
            tmux_pkg::ST_WALK:
            begin
                if (stat.walk_fire)
                begin
                    ctrl.fire_mark = 1'b1;
                    state_next = tmux_pkg::ST_FIRE;
                end
                else
                begin
                    ctrl.walk_step = 1'b1;
                    if (stat.walk_done)
                        state_next = tmux_pkg::ST_FINAL;
                end
            end
            tmux_pkg::ST_FIRE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.walk_step = 1'b1;
                    state_next = stat.walk_done ? tmux_pkg::ST_FINAL : tmux_pkg::ST_WALK;
                end
            end
            tmux_pkg::ST_FINAL:
            begin
                ctrl.finish = 1'b1;
                state_next = tmux_pkg::ST_OUT;
            end
            tmux_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                out_last = 1'b1;
                if (out_ready)
                    state_next = tmux_pkg::ST_IDLE;
            end
            default: state_next = tmux_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/tmux_dp.sv
// Datapath: timer table, command execution and expiry walk.
module tmux_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [2:0]                  cmd,
    input  logic [tmux_pkg::SLOT_W-1:0] handle,
    input  logic                        one_shot,
    input  logic [31:0]                 period_ticks,
    input  logic [31:0]                 hw_remaining,
    input  tmux_pkg::ctrl_t             ctrl,
    output tmux_pkg::stat_t             stat,
    output logic                        status,
    output logic [tmux_pkg::SLOT_W-1:0] slot,
    output logic [31:0]                 hw_period,
    output logic                        hw_enable
);

    logic [2:0]                  cmd_reg;
    logic [tmux_pkg::SLOT_W-1:0] hd_reg;
    logic                        shot_reg;
    logic [31:0]                 per_reg, rem_reg;
    logic [tmux_pkg::TIMERS-1:0] created_reg, started_reg, oneshot_reg;
    logic [31:0]                 period_mem [tmux_pkg::TIMERS];
    logic [31:0]                 fire_mem [tmux_pkg::TIMERS];
    logic [31:0]                 hwp_reg;
    logic [tmux_pkg::CNT_W-1:0]  count_reg;
    logic                        en_reg;
    logic                        status_reg;
    logic [tmux_pkg::SLOT_W-1:0] slot_reg, idx_reg;
    logic [31:0]                 min_reg;
    logic                        found_reg;

    logic                        free_found;
    logic [tmux_pkg::SLOT_W-1:0] free_idx;
    logic [31:0]                 cur_fire, cur_per, new_fire;
    logic                        cur_due, cur_keep;

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = tmux_pkg::TIMERS - 1; i >= 0; i--)
        begin
            if (!created_reg[i])
            begin
                free_found = 1'b1;
                free_idx = tmux_pkg::SLOT_W'(i);
            end
        end
    end

    assign cur_fire = fire_mem[idx_reg];
    assign cur_per  = period_mem[idx_reg];
    assign cur_due  = started_reg[idx_reg] && (cur_fire <= hwp_reg);
    assign new_fire = cur_due ? cur_per : cur_fire - hwp_reg;
    assign cur_keep = started_reg[idx_reg] && !(cur_due && oneshot_reg[idx_reg]);

    assign stat.is_expire = (cmd_reg == tmux_pkg::CMD_EXPIRE);
    assign stat.walk_fire = cur_due;
    assign stat.walk_done = (idx_reg == tmux_pkg::SLOT_W'(tmux_pkg::TIMERS - 1));

    assign status    = status_reg;
    assign slot      = slot_reg;
    assign hw_period = hwp_reg;
    assign hw_enable = en_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd;
            hd_reg <= handle;
            shot_reg <= one_shot;
            per_reg <= period_ticks;
            rem_reg <= hw_remaining;
        end
        if (ctrl.exec && cmd_reg == tmux_pkg::CMD_CREATE && free_found)
            period_mem[free_idx] <= per_reg;
        if (ctrl.exec && cmd_reg == tmux_pkg::CMD_SETPER && created_reg[hd_reg]
            && !started_reg[hd_reg] && oneshot_reg[hd_reg])
            period_mem[hd_reg] <= per_reg;
        if (ctrl.exec && cmd_reg == tmux_pkg::CMD_START && created_reg[hd_reg]
            && !started_reg[hd_reg])
            fire_mem[hd_reg] <= (rem_reg > period_mem[hd_reg]) ? period_mem[hd_reg]
                                : period_mem[hd_reg] - rem_reg;
        if (ctrl.walk_step && started_reg[idx_reg])
            fire_mem[idx_reg] <= new_fire;
        if (ctrl.walk_step && cur_keep && (!found_reg || new_fire < min_reg))
            min_reg <= new_fire;
        if (ctrl.walk_first)
        begin
            status_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (ctrl.fire_mark)
            slot_reg <= idx_reg;
        else if (ctrl.finish)
            slot_reg <= '0;
        if (ctrl.exec)
        begin
            unique case (cmd_reg)
                tmux_pkg::CMD_CREATE:
                begin
                    status_reg <= !free_found;
                    slot_reg <= free_found ? free_idx : '0;
                end
                tmux_pkg::CMD_START:
                begin
                    status_reg <= !(created_reg[hd_reg] && !started_reg[hd_reg]);
                    slot_reg <= hd_reg;
                end
                tmux_pkg::CMD_STOP:
                begin
                    status_reg <= !started_reg[hd_reg];
                    slot_reg <= hd_reg;
                end
                tmux_pkg::CMD_SETPER:
                begin
                    status_reg <= !(created_reg[hd_reg] && !started_reg[hd_reg]
                                    && oneshot_reg[hd_reg]);
                    slot_reg <= hd_reg;
                end
                default:
                begin
                    status_reg <= 1'b1;
                    slot_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            created_reg <= '0;
            started_reg <= '0;
            oneshot_reg <= '0;
            hwp_reg <= tmux_pkg::ALL_ONES;
            count_reg <= '0;
            en_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                unique case (cmd_reg)
                    tmux_pkg::CMD_CREATE:
                        if (free_found)
                        begin
                            created_reg[free_idx] <= 1'b1;
                            started_reg[free_idx] <= 1'b0;
                            oneshot_reg[free_idx] <= shot_reg;
                        end
                    tmux_pkg::CMD_START:
                        if (created_reg[hd_reg] && !started_reg[hd_reg])
                        begin
                            started_reg[hd_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            if (rem_reg > period_mem[hd_reg])
                                hwp_reg <= period_mem[hd_reg];
                            if (count_reg == '0)
                                en_reg <= 1'b1;
                        end
                    tmux_pkg::CMD_STOP:
                        if (started_reg[hd_reg])
                        begin
                            started_reg[hd_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                            if (count_reg == tmux_pkg::CNT_W'(1))
                                en_reg <= 1'b0;
                        end
                    default: ;
                endcase
            end
            if (ctrl.walk_first)
            begin
                en_reg <= 1'b0;
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            if (ctrl.walk_step)
            begin
                if (cur_due && oneshot_reg[idx_reg])
                begin
                    started_reg[idx_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                end
                if (cur_keep)
                    found_reg <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctrl.finish)
            begin
                if (found_reg)
                    hwp_reg <= min_reg;
                en_reg <= (count_reg != '0);
            end
        end
    end

endmodule

FILE: rtl/timer_multiplexer_unit.sv
// Top level of the timer multiplexer.
// Usage:
//   s_axis carries one command beat: cmd, handle, one_shot, period_ticks,
//   hw_remaining packed into tdata from the lowest bit.
//   m_axis carries result beats: tdata holds status, slot, fired, hw_period,
//   hw_enable; tlast marks the final result of a command.
//   Create, start, stop and set period give one result, registered in the
//   EXEC state and offered in OUT; the next command is taken back in IDLE.
//   Expire walks the sixteen slots one a cycle, pausing in the FIRE state at
//   each firing timer and holding there until its beat is taken, then gives
//   the final beat. One command is held at a time; s_axis_tready is low
//   until the last result beat is taken.
//   Reset empties the timer table, sets the hardware period to all ones and
//   clears the enable. A stalled receiver holds the current beat steady.
module timer_multiplexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd, handle, one_shot, period_ticks, hw_remaining
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status, slot, fired, hw_period, hw_enable, pad
    output logic        m_axis_tlast
);

    tmux_pkg::ctrl_t ctrl;
    tmux_pkg::stat_t stat;
    logic                        status, hw_enable, fired;
    logic [tmux_pkg::SLOT_W-1:0] slot;
    logic [31:0]                 hw_period;

    tmux_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    tmux_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s_axis_tvalid && s_axis_tready),
        .cmd          (s_axis_tdata[2:0]),
        .handle       (s_axis_tdata[6:3]),
        .one_shot     (s_axis_tdata[7]),
        .period_ticks (s_axis_tdata[39:8]),
        .hw_remaining (s_axis_tdata[71:40]),
        .ctrl         (ctrl),
        .stat         (stat),
        .status       (status),
        .slot         (slot),
        .hw_period    (hw_period),
        .hw_enable    (hw_enable)
    );

    assign fired = m_axis_tvalid && !m_axis_tlast;
    assign m_axis_tdata = {1'b0, hw_enable, hw_period, fired, slot, status};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_fire_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (!hw_enable && !status))
        else $error("fired beat with enable or error set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

FILE: dv/tb_timer_multiplexer_unit.sv
// Self-checking testbench for timer_multiplexer_unit: command stream, slot table predictor.
`timescale 1ns / 100ps

module tb_timer_multiplexer_unit;

    localparam int WDOG_LIMIT = 4000;
    localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0] CMD_BAD_LAST = 3'd7;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot;
        logic        fired;
        logic [31:0] hw_period;
        logic        hw_enable;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    // timer table copy
    bit          tbl_created [tmux_pkg::TIMERS];
    bit          tbl_started [tmux_pkg::TIMERS];
    bit          tbl_one_shot [tmux_pkg::TIMERS];
    logic [31:0] tbl_period [tmux_pkg::TIMERS];
    logic [31:0] tbl_fire_in [tmux_pkg::TIMERS];
    logic [31:0] hw_period_now = tmux_pkg::ALL_ONES;
    int          n_started = 0;
    bit          irq_en = 1'b0;
    result_t     pending_results [$];

    timer_multiplexer_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic void push_result(logic status, logic [3:0] slot, logic fired,
                                        logic last);
        result_t r;
        r.status = status;
        r.slot = slot;
        r.fired = fired;
        r.hw_period = hw_period_now;
        r.hw_enable = irq_en;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    function automatic void schedule_command(logic [2:0] cmd, logic [3:0] hd, logic shot,
                                             logic [31:0] per, logic [31:0] rem);
        bit ok;
        bit found;
        logic [31:0] min_left;
        ok = 1'b0;
        found = 1'b0;
        min_left = tmux_pkg::ALL_ONES;
        case (cmd)
            tmux_pkg::CMD_CREATE:
            begin
                for (int i = 0; i < tmux_pkg::TIMERS; i++)
                begin
                    if (!ok && !tbl_created[i])
                    begin
                        ok = 1'b1;
                        tbl_created[i] = 1'b1;
                        tbl_started[i] = 1'b0;
                        tbl_one_shot[i] = shot;
                        tbl_period[i] = per;
                        push_result(1'b0, 4'(i), 1'b0, 1'b1);
                    end
                end
                if (!ok)
                    push_result(1'b1, 4'd0, 1'b0, 1'b1);
            end
            tmux_pkg::CMD_START:
            begin
                if (tbl_created[hd] && !tbl_started[hd])
                begin
                    ok = 1'b1;
                    tbl_started[hd] = 1'b1;
                    n_started++;
                    if (rem > tbl_period[hd])
                    begin
                        tbl_fire_in[hd] = tbl_period[hd];
                        hw_period_now = tbl_period[hd];
                    end
                    else
                        tbl_fire_in[hd] = tbl_period[hd] - rem;
                    if (n_started == 1)
                        irq_en = 1'b1;
                end
                push_result(!ok, hd, 1'b0, 1'b1);
            end
            tmux_pkg::CMD_STOP:
            begin
                if (tbl_started[hd])
                begin
                    ok = 1'b1;
                    tbl_started[hd] = 1'b0;
                    n_started--;
                    if (n_started == 0)
                        irq_en = 1'b0;
                end
                push_result(!ok, hd, 1'b0, 1'b1);
            end
            tmux_pkg::CMD_SETPER:
            begin
                if (tbl_created[hd] && !tbl_started[hd] && tbl_one_shot[hd])
                begin
                    ok = 1'b1;
                    tbl_period[hd] = per;
                end
                push_result(!ok, hd, 1'b0, 1'b1);
            end
            tmux_pkg::CMD_EXPIRE:
            begin
                irq_en = 1'b0;
                for (int i = 0; i < tmux_pkg::TIMERS; i++)
                begin
                    if (tbl_started[i])
                    begin
                        if (tbl_fire_in[i] <= hw_period_now)
                        begin
                            if (tbl_one_shot[i])
                            begin
                                tbl_started[i] = 1'b0;
                                n_started--;
                            end
                            push_result(1'b0, 4'(i), 1'b1, 1'b0);
                            tbl_fire_in[i] = tbl_period[i];
                        end
                        else
                            tbl_fire_in[i] = tbl_fire_in[i] - hw_period_now;
                        if (tbl_started[i] && (!found || tbl_fire_in[i] < min_left))
                        begin
                            found = 1'b1;
                            min_left = tbl_fire_in[i];
                        end
                    end
                end
                if (found)
                    hw_period_now = min_left;
                if (n_started >= 1)
                    irq_en = 1'b1;
                push_result(1'b0, 4'd0, 1'b0, 1'b1);
            end
            default:
                push_result(1'b1, 4'd0, 1'b0, 1'b1);
        endcase
    endfunction

    // called and returns at a falling edge; valid stays up between back-to-back beats
    task automatic send_command(logic [2:0] cmd, logic [3:0] hd, logic shot,
                                logic [31:0] per, logic [31:0] rem);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        schedule_command(cmd, hd, shot, per, rem);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rem, per, shot, hd, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(40);
        else if (r < 80)
            return $urandom_range(1000);
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_remaining();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return tmux_pkg::ALL_ONES;
        else if (r < 75)
            return $urandom_range(60);
        else
            return $urandom;
    endfunction

    task automatic test_directed();
        send_command(tmux_pkg::CMD_EXPIRE, 4'd0, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_START, 4'd0, 1'b0, '0, tmux_pkg::ALL_ONES);
        send_command(tmux_pkg::CMD_STOP, 4'd0, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_SETPER, 4'd0, 1'b0, 32'd5, '0);
        send_command(tmux_pkg::CMD_CREATE, 4'd0, 1'b1, 32'd0, '0);
        send_command(tmux_pkg::CMD_CREATE, 4'd0, 1'b0, tmux_pkg::ALL_ONES, '0);
        send_command(tmux_pkg::CMD_CREATE, 4'd0, 1'b0, 32'd10, '0);
        send_command(tmux_pkg::CMD_SETPER, 4'd0, 1'b0, 32'd3, '0);
        send_command(tmux_pkg::CMD_SETPER, 4'd2, 1'b0, 32'd7, '0);
        send_command(tmux_pkg::CMD_START, 4'd0, 1'b0, '0, tmux_pkg::ALL_ONES);
        send_command(tmux_pkg::CMD_START, 4'd0, 1'b0, '0, tmux_pkg::ALL_ONES);
        send_command(tmux_pkg::CMD_SETPER, 4'd0, 1'b0, 32'd9, '0);
        send_command(tmux_pkg::CMD_START, 4'd2, 1'b0, '0, 32'd4);
        send_command(tmux_pkg::CMD_START, 4'd1, 1'b0, '0, 32'd0);
        send_command(tmux_pkg::CMD_EXPIRE, 4'd0, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_EXPIRE, 4'd0, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_STOP, 4'd1, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_STOP, 4'd15, 1'b0, '0, '0);
        send_command(CMD_BAD_FIRST, 4'hF, 1'b1, tmux_pkg::ALL_ONES, tmux_pkg::ALL_ONES);
        send_command(CMD_BAD_LAST, 4'd3, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_STOP, 4'd2, 1'b0, '0, '0);
        send_command(tmux_pkg::CMD_EXPIRE, 4'd0, 1'b0, '0, '0);
    endtask

    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int r;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_command(tmux_pkg::CMD_CREATE, 4'($urandom), 1'($urandom),
                             pick_period(), $urandom);
            else if (r < 38)
                send_command(tmux_pkg::CMD_START, 4'($urandom), 1'($urandom), $urandom,
                             pick_remaining());
            else if (r < 52)
                send_command(tmux_pkg::CMD_STOP, 4'($urandom), 1'($urandom), $urandom,
                             $urandom);
            else if (r < 60)
                send_command(tmux_pkg::CMD_SETPER, 4'($urandom), 1'($urandom),
                             pick_period(), $urandom);
            else if (r < 96)
                send_command(tmux_pkg::CMD_EXPIRE, 4'($urandom), 1'($urandom), $urandom,
                             $urandom);
            else
                send_command(3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST)), 4'($urandom),
                             1'($urandom), $urandom, $urandom);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h last %b", $time, m_axis_tdata,
                         m_axis_tlast);
                errors++;
            end
            else
            begin
                result_t want;
                result_t got;
                want = pending_results.pop_front();
                got.status = m_axis_tdata[0];
                got.slot = m_axis_tdata[4:1];
                got.fired = m_axis_tdata[5];
                got.hw_period = m_axis_tdata[37:6];
                got.hw_enable = m_axis_tdata[38];
                got.last = m_axis_tlast;
                if (got !== want)
                begin
                    $display("%0t: mismatch expected st %b slot %0d fired %b per %h en %b last %b",
                             $time, want.status, want.slot, want.fired, want.hw_period,
                             want.hw_enable, want.last);
                    $display("%0t:          actual   st %b slot %0d fired %b per %h en %b last %b",
                             $time, got.status, got.slot, got.fired, got.hw_period,
                             got.hw_enable, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("tb_timer_multiplexer_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(65, 0, 0);
        test_random(65, 74, 0);
        test_random(65, 0, 74);
        test_random(65, 25, 25);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("tb_timer_multiplexer_unit OK");
        else
            $display("tb_timer_multiplexer_unit NOT OK");
        $finish;
    end

endmodule
